### design/kce_pkg.sv
// Shared types and constants for the keypad calculator entry block.
// Used by kce_alu and keypad_calculator_entry_core; depends on nothing.
`default_nettype none

package kce_pkg;

    localparam int unsigned DIGITS_DEF = 3;

    localparam int unsigned KEY_W     = 8;
    localparam int unsigned OPERAND_W = 10;
    localparam int unsigned VALUE_W   = 21;
    localparam int unsigned PROD_W    = 20;
    localparam int unsigned CNT_W     = 2;
    localparam int unsigned STEP_W    = 4;
    localparam int unsigned TDATA_W   = 32;

    localparam logic [KEY_W-1:0] KEY_PLUS  = 8'h2B;
    localparam logic [KEY_W-1:0] KEY_MINUS = 8'h2D;
    localparam logic [KEY_W-1:0] KEY_STAR  = 8'h2A;
    localparam logic [KEY_W-1:0] KEY_SLASH = 8'h2F;
    localparam logic [KEY_W-1:0] KEY_ZERO  = 8'h30;
    localparam logic [KEY_W-1:0] KEY_NINE  = 8'h39;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } kce_op_t;

    typedef enum logic [1:0] {
        PH_FIRST  = 2'd0,
        PH_OPER   = 2'd1,
        PH_SECOND = 2'd2
    } kce_phase_t;

    typedef enum logic [1:0] {
        CTL_IDLE = 2'd0,
        CTL_CALC = 2'd1,
        CTL_PUSH = 2'd2
    } kce_ctl_state_t;

    typedef enum logic [1:0] {
        ALU_IDLE = 2'd0,
        ALU_ITER = 2'd1,
        ALU_DONE = 2'd2
    } kce_alu_state_t;

    typedef struct packed {
        logic    start;
        kce_op_t op;
    } kce_alu_req_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic div_err;
    } kce_alu_rsp_t;

endpackage

`default_nettype wire

### design/kce_alu.sv
// Iterative arithmetic unit: one shared 21-bit adder/subtractor under a small
// sequencer does add, subtract, shift-add multiply and restoring divide.
// Depends on kce_pkg.
`default_nettype none

module kce_alu (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire kce_pkg::kce_alu_req_t             req,
    input  wire logic [kce_pkg::OPERAND_W-1:0]     opa_in,
    input  wire logic [kce_pkg::OPERAND_W-1:0]     opb_in,
    output kce_pkg::kce_alu_rsp_t                  rsp,
    output logic      [kce_pkg::VALUE_W-1:0]       result
);

    kce_pkg::kce_alu_state_t              state_reg, state_next;
    kce_pkg::kce_op_t                     op_reg, op_next;
    logic                                 err_reg, err_next;
    logic [kce_pkg::VALUE_W-1:0]          acc_reg, acc_next;
    logic [kce_pkg::PROD_W-1:0]           mcand_reg, mcand_next;
    logic [kce_pkg::OPERAND_W-1:0]        opb_reg, opb_next;
    logic [kce_pkg::STEP_W-1:0]           step_reg, step_next;

    logic [kce_pkg::OPERAND_W:0]          rem_shift;
    logic [kce_pkg::VALUE_W-1:0]          add_x, add_y, sum;
    logic                                 add_sub;
    logic                                 last_step;
    logic                                 div_zero;

    assign div_zero  = (req.op == kce_pkg::OP_DIV) && (opb_in == '0);
    assign last_step = (step_reg == kce_pkg::STEP_W'(kce_pkg::OPERAND_W - 1));
    assign rem_shift = {acc_reg[kce_pkg::OPERAND_W-1:0], opb_reg[kce_pkg::OPERAND_W-1]};

    // Shared adder: operand select by operation
    always_comb begin
        add_x   = kce_pkg::VALUE_W'(mcand_reg[kce_pkg::OPERAND_W-1:0]);
        add_y   = kce_pkg::VALUE_W'(opb_reg);
        add_sub = 1'b0;
        case (op_reg)
            kce_pkg::OP_MUL: begin
                add_x = acc_reg;
                add_y = opb_reg[0] ? kce_pkg::VALUE_W'(mcand_reg) : '0;
            end
            kce_pkg::OP_DIV: begin
                add_x   = kce_pkg::VALUE_W'(rem_shift);
                add_y   = kce_pkg::VALUE_W'(mcand_reg[kce_pkg::OPERAND_W-1:0]);
                add_sub = 1'b1;
            end
            kce_pkg::OP_SUB: begin
                add_sub = 1'b1;
            end
            default: begin
                add_sub = 1'b0;
            end
        endcase
        sum = add_x + (add_y ^ {kce_pkg::VALUE_W{add_sub}})
            + kce_pkg::VALUE_W'(add_sub);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kce_pkg::ALU_IDLE: begin
                if (req.start) begin
                    state_next = div_zero ? kce_pkg::ALU_DONE : kce_pkg::ALU_ITER;
                end
            end
            kce_pkg::ALU_ITER: begin
                if (op_reg == kce_pkg::OP_ADD || op_reg == kce_pkg::OP_SUB || last_step) begin
                    state_next = kce_pkg::ALU_DONE;
                end
            end
            kce_pkg::ALU_DONE: begin
                state_next = kce_pkg::ALU_IDLE;
            end
            default: begin
                state_next = kce_pkg::ALU_IDLE;
            end
        endcase
    end

    // Datapath next values
    always_comb begin
        op_next    = op_reg;
        err_next   = err_reg;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        opb_next   = opb_reg;
        step_next  = step_reg;
        unique case (state_reg)
            kce_pkg::ALU_IDLE: begin
                if (req.start) begin
                    op_next   = req.op;
                    err_next  = div_zero;
                    acc_next  = '0;
                    step_next = '0;
                    if (req.op == kce_pkg::OP_DIV) begin
                        mcand_next = kce_pkg::PROD_W'(opb_in);
                        opb_next   = opa_in;
                    end else begin
                        mcand_next = kce_pkg::PROD_W'(opa_in);
                        opb_next   = opb_in;
                    end
                end
            end
            kce_pkg::ALU_ITER: begin
                step_next = step_reg + 1'b1;
                case (op_reg)
                    kce_pkg::OP_MUL: begin
                        acc_next   = sum;
                        mcand_next = {mcand_reg[kce_pkg::PROD_W-2:0], 1'b0};
                        opb_next   = {1'b0, opb_reg[kce_pkg::OPERAND_W-1:1]};
                    end
                    kce_pkg::OP_DIV: begin
                        // keep the shifted remainder when the trial subtract goes negative
                        acc_next = sum[kce_pkg::VALUE_W-1] ? kce_pkg::VALUE_W'(rem_shift) : sum;
                        opb_next = {opb_reg[kce_pkg::OPERAND_W-2:0], ~sum[kce_pkg::VALUE_W-1]};
                    end
                    default: begin
                        acc_next = sum;
                    end
                endcase
            end
            default: begin
                step_next = step_reg;
            end
        endcase
    end

    // Outputs
    always_comb begin
        rsp.busy    = (state_reg != kce_pkg::ALU_IDLE);
        rsp.done    = (state_reg == kce_pkg::ALU_DONE);
        rsp.div_err = err_reg;
        if (err_reg) begin
            result = '0;
        end else if (op_reg == kce_pkg::OP_DIV) begin
            result = kce_pkg::VALUE_W'(opb_reg);
        end else begin
            result = acc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= kce_pkg::ALU_IDLE;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
        op_reg    <= op_next;
        err_reg   <= err_next;
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        opb_reg   <= opb_next;
    end

endmodule

`default_nettype wire

### design/keypad_calculator_entry_core.sv
// Top level of the keypad calculator entry block: key decoding, operand
// entry, control sequencer and output register. Depends on kce_pkg, kce_alu.
`default_nettype none

// Keypad calculator entry. Send one ASCII key code per input item. The block
// takes DIGITS decimal digits for the first operand, one of + - * /, then
// DIGITS digits for the second operand; keys that do not fit the current
// entry phase are dropped without a result. Every taken key is echoed as one
// result item. The last digit of the second operand also raises m_tlast and
// carries the signed 21-bit sum, difference, product or truncated quotient,
// or m_tuser (divide error) on a division by zero, and the entry starts over.
// Handshake: a dropped key leaves s_tready high; a key that gives a plain
// echo holds it low until the echo enters the output register; the last
// digit holds it low while the shared arithmetic unit runs (multiply and
// divide: ten iterations, one partial product or quotient bit per cycle
// over the 10 operand bits, then a done state; division by zero: the done
// state only) and until the result enters the output register. A finished
// result sits in the output register while the next key is taken; a result
// waits for that register only when the previous one has not yet been read,
// and s_tready stays low for as long as it waits.
module keypad_calculator_entry_core #(
    parameter int unsigned DIGITS = kce_pkg::DIGITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    // s_tdata: [7:0] key
    input  wire logic [kce_pkg::KEY_W-1:0]    s_tdata,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // m_tdata: [7:0] echo_key, [28:8] value
    output logic [kce_pkg::TDATA_W-1:0]       m_tdata,
    // m_tuser: [0] divide_error
    output logic                              m_tuser,
    output logic                              m_tlast,
    output logic                              m_tvalid,
    input  wire logic                         m_tready
);

    localparam int unsigned PROD_FULL_W = kce_pkg::OPERAND_W + 4;

    // Sequencer and entry state
    kce_pkg::kce_ctl_state_t             ctl_state_reg, ctl_state_next;
    kce_pkg::kce_phase_t                 phase_reg, phase_next;
    logic [kce_pkg::CNT_W-1:0]           count_reg, count_next;
    logic [kce_pkg::OPERAND_W-1:0]       first_reg, first_next;
    logic [kce_pkg::OPERAND_W-1:0]       second_reg, second_next;
    kce_pkg::kce_op_t                    op_reg, op_next;

    // Pending result and output register
    logic [kce_pkg::KEY_W-1:0]           pend_key_reg;
    logic                                pend_final_reg;
    logic [kce_pkg::VALUE_W-1:0]         pend_value_reg;
    logic                                pend_err_reg;
    logic                                m_tvalid_reg, m_tvalid_next;
    logic [kce_pkg::KEY_W-1:0]           m_key_reg;
    logic                                m_final_reg;
    logic [kce_pkg::VALUE_W-1:0]         m_value_reg;
    logic                                m_err_reg;

    // Decode
    logic                                in_fire;
    logic                                is_digit;
    logic                                is_oper;
    logic                                key_ok;
    logic                                last_digit;
    logic                                out_free;
    logic                                out_load;
    logic                                pend_load;
    logic                                calc_capture;
    logic [kce_pkg::CNT_W:0]             count_inc;
    logic [kce_pkg::OPERAND_W-1:0]       accum_src;
    logic [PROD_FULL_W-1:0]              accum_wide;
    logic [kce_pkg::OPERAND_W-1:0]       alu_opb;
    kce_pkg::kce_op_t                    key_op;

    kce_pkg::kce_alu_req_t               alu_req;
    kce_pkg::kce_alu_rsp_t               alu_rsp;
    logic [kce_pkg::VALUE_W-1:0]         alu_result;

    assign in_fire  = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign is_digit = (s_tdata >= kce_pkg::KEY_ZERO) && (s_tdata <= kce_pkg::KEY_NINE);

    // Operator key decode
    always_comb begin
        is_oper = 1'b1;
        key_op  = kce_pkg::OP_ADD;
        unique case (s_tdata)
            kce_pkg::KEY_PLUS:  key_op = kce_pkg::OP_ADD;
            kce_pkg::KEY_MINUS: key_op = kce_pkg::OP_SUB;
            kce_pkg::KEY_STAR:  key_op = kce_pkg::OP_MUL;
            kce_pkg::KEY_SLASH: key_op = kce_pkg::OP_DIV;
            default:            is_oper = 1'b0;
        endcase
    end

    // Operand accumulate: value * 10 + digit, digit is the low nibble of the code
    assign count_inc  = {1'b0, count_reg} + 1'b1;
    assign accum_src  = (phase_reg == kce_pkg::PH_SECOND) ? second_reg : first_reg;
    assign accum_wide = (PROD_FULL_W'(accum_src) << 3) + (PROD_FULL_W'(accum_src) << 1)
                      + PROD_FULL_W'(s_tdata[3:0]);

    // Second operand as it stands after the last digit is folded in
    assign alu_opb = (phase_reg == kce_pkg::PH_SECOND) ? accum_wide[kce_pkg::OPERAND_W-1:0]
                                                       : second_reg;

    // Entry state update on a taken key
    always_comb begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        first_next  = first_reg;
        second_next = second_reg;
        op_next     = op_reg;
        key_ok      = 1'b0;
        last_digit  = 1'b0;
        unique case (phase_reg)
            kce_pkg::PH_OPER: begin
                key_ok = is_oper;
                if (is_oper) begin
                    op_next    = key_op;
                    phase_next = kce_pkg::PH_SECOND;
                end
            end
            kce_pkg::PH_SECOND: begin
                key_ok = is_digit;
                if (is_digit) begin
                    second_next = accum_wide[kce_pkg::OPERAND_W-1:0];
                    count_next  = count_inc[kce_pkg::CNT_W-1:0];
                    if (count_inc >= (kce_pkg::CNT_W+1)'(DIGITS)) begin
                        // complete: hand operands to the ALU and start over
                        last_digit = 1'b1;
                        phase_next = kce_pkg::PH_FIRST;
                        count_next = '0;
                        first_next = '0;
                        second_next = '0;
                        op_next    = kce_pkg::OP_ADD;
                    end
                end
            end
            default: begin
                key_ok = is_digit;
                if (is_digit) begin
                    first_next = accum_wide[kce_pkg::OPERAND_W-1:0];
                    count_next = count_inc[kce_pkg::CNT_W-1:0];
                    phase_next = kce_pkg::PH_FIRST;
                    if (count_inc >= (kce_pkg::CNT_W+1)'(DIGITS)) begin
                        count_next = '0;
                        phase_next = kce_pkg::PH_OPER;
                    end
                end
            end
        endcase
    end

    // Sequencer next state
    always_comb begin
        ctl_state_next = ctl_state_reg;
        unique case (ctl_state_reg)
            kce_pkg::CTL_IDLE: begin
                if (s_tvalid && key_ok) begin
                    ctl_state_next = last_digit ? kce_pkg::CTL_CALC : kce_pkg::CTL_PUSH;
                end
            end
            kce_pkg::CTL_CALC: begin
                if (alu_rsp.done) begin
                    ctl_state_next = kce_pkg::CTL_PUSH;
                end
            end
            kce_pkg::CTL_PUSH: begin
                if (out_free) begin
                    ctl_state_next = kce_pkg::CTL_IDLE;
                end
            end
            default: begin
                ctl_state_next = kce_pkg::CTL_IDLE;
            end
        endcase
    end

    // Sequencer outputs
    always_comb begin
        s_tready      = 1'b0;
        pend_load     = 1'b0;
        calc_capture  = 1'b0;
        out_load      = 1'b0;
        alu_req.start = 1'b0;
        alu_req.op    = op_reg;
        unique case (ctl_state_reg)
            kce_pkg::CTL_IDLE: begin
                s_tready      = 1'b1;
                pend_load     = s_tvalid && key_ok;
                alu_req.start = s_tvalid && key_ok && last_digit;
            end
            kce_pkg::CTL_CALC: begin
                calc_capture = alu_rsp.done;
            end
            kce_pkg::CTL_PUSH: begin
                out_load = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    kce_alu u_alu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (alu_req),
        .opa_in  (first_reg),
        .opb_in  (alu_opb),
        .rsp     (alu_rsp),
        .result  (alu_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_state_reg <= kce_pkg::CTL_IDLE;
            phase_reg     <= kce_pkg::PH_FIRST;
            count_reg     <= '0;
            first_reg     <= '0;
            second_reg    <= '0;
            op_reg        <= kce_pkg::OP_ADD;
            m_tvalid_reg  <= 1'b0;
        end else begin
            ctl_state_reg <= ctl_state_next;
            m_tvalid_reg  <= m_tvalid_next;
            if (pend_load) begin
                phase_reg  <= phase_next;
                count_reg  <= count_next;
                first_reg  <= first_next;
                second_reg <= second_next;
                op_reg     <= op_next;
            end
        end
    end

    // Pending and output payload: no reset needed
    always_ff @(posedge aclk) begin
        if (pend_load) begin
            pend_key_reg   <= s_tdata;
            pend_final_reg <= last_digit;
            pend_value_reg <= '0;
            pend_err_reg   <= 1'b0;
        end else if (calc_capture) begin
            pend_value_reg <= alu_result;
            pend_err_reg   <= alu_rsp.div_err;
        end
        if (out_load) begin
            m_key_reg   <= pend_key_reg;
            m_final_reg <= pend_final_reg;
            m_value_reg <= pend_value_reg;
            m_err_reg   <= pend_err_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b0, m_value_reg, m_key_reg};
    assign m_tlast  = m_final_reg;
    assign m_tuser  = m_err_reg;

    // Checks on the sequencer and the shared unit
    a_no_accept_while_alu_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_rsp.busy |-> !s_tready)
        else $error("key accepted while arithmetic unit busy");

    a_alu_done_only_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_rsp.done |-> (ctl_state_reg == kce_pkg::CTL_CALC))
        else $error("arithmetic result outside calculation phase");

    a_err_only_on_final: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_err_reg |-> m_final_reg && (m_value_reg == '0))
        else $error("divide error on a non-final or nonzero result");

    a_nonfinal_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_final_reg |-> (m_value_reg == '0))
        else $error("echo item carries a nonzero value");

    a_start_from_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        alu_req.start |=> alu_rsp.busy && (ctl_state_reg == kce_pkg::CTL_CALC))
        else $error("arithmetic start did not enter calculation");

endmodule

`default_nettype wire

### tb/tb.sv
// Self-checking testbench for keypad_calculator_entry_core: directed and random
// key streams, idle gaps on both channels, a long output stall.
// Depends on kce_pkg and the keypad_calculator_entry_core RTL.
`default_nettype none

module tb;

    localparam int unsigned N_DIGITS = kce_pkg::DIGITS_DEF;
    localparam int unsigned RANDOM_KEYS = 1400;

    // Fields of one result item: tuser, tdata value, tlast, tdata key.
    typedef struct packed {
        logic                        div_err;
        logic [kce_pkg::VALUE_W-1:0] value;
        logic                        fin;
        logic [kce_pkg::KEY_W-1:0]   echo;
    } key_result_t;

    logic                           aclk;
    logic                           aresetn;
    logic [kce_pkg::KEY_W-1:0]      s_tdata;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [kce_pkg::TDATA_W-1:0]    m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;
    logic                           m_tvalid;
    logic                           m_tready;

    // Calculator state as the predictor sees it.
    kce_pkg::kce_phase_t            entry_phase;
    logic [kce_pkg::CNT_W-1:0]      digits_taken;
    logic [kce_pkg::OPERAND_W-1:0]  lhs_value;
    logic [kce_pkg::OPERAND_W-1:0]  rhs_value;
    kce_pkg::kce_op_t               pending_op;

    key_result_t           pending_results[$];
    int                    keys_taken;
    int                    fail_count;
    bit                    src_idle_on;
    bit                    sink_idle_on;
    int                    sink_hold_cycles;

    logic [kce_pkg::KEY_W-1:0] op_keys[4] = '{kce_pkg::KEY_PLUS, kce_pkg::KEY_MINUS,
                                              kce_pkg::KEY_STAR, kce_pkg::KEY_SLASH};

    keypad_calculator_entry_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    function automatic void clear_entry();
        entry_phase  = kce_pkg::PH_FIRST;
        digits_taken = '0;
        lhs_value    = '0;
        rhs_value    = '0;
        pending_op   = kce_pkg::OP_ADD;
    endfunction

    // Advance the calculator by one key; return 1 when the key is taken and
    // yields a result item, 0 when it is dropped.
    function automatic bit calc_key_result(input logic [kce_pkg::KEY_W-1:0] key,
                                           output key_result_t r);
        logic                        is_digit;
        logic [kce_pkg::VALUE_W-1:0] lhs_w;
        logic [kce_pkg::VALUE_W-1:0] rhs_w;
        r        = '0;
        r.echo   = key;
        is_digit = (key >= kce_pkg::KEY_ZERO) && (key <= kce_pkg::KEY_NINE);
        case (entry_phase)
            kce_pkg::PH_OPER: begin
                if (key == kce_pkg::KEY_PLUS) pending_op = kce_pkg::OP_ADD;
                else if (key == kce_pkg::KEY_MINUS) pending_op = kce_pkg::OP_SUB;
                else if (key == kce_pkg::KEY_STAR) pending_op = kce_pkg::OP_MUL;
                else if (key == kce_pkg::KEY_SLASH) pending_op = kce_pkg::OP_DIV;
                else return 1'b0;
                entry_phase = kce_pkg::PH_SECOND;
            end
            kce_pkg::PH_SECOND: begin
                if (!is_digit) return 1'b0;
                rhs_value    = kce_pkg::OPERAND_W'(rhs_value * 10 + (key - kce_pkg::KEY_ZERO));
                digits_taken = digits_taken + 1'b1;
                if (digits_taken >= N_DIGITS) begin
                    lhs_w = kce_pkg::VALUE_W'(lhs_value);
                    rhs_w = kce_pkg::VALUE_W'(rhs_value);
                    r.fin = 1'b1;
                    case (pending_op)
                        kce_pkg::OP_ADD: r.value = lhs_w + rhs_w;
                        kce_pkg::OP_SUB: r.value = lhs_w - rhs_w;
                        kce_pkg::OP_MUL: r.value = lhs_w * rhs_w;
                        default: begin
                            if (rhs_w == '0) r.div_err = 1'b1;
                            else r.value = lhs_w / rhs_w;
                        end
                    endcase
                    clear_entry();
                end
            end
            default: begin
                if (!is_digit) return 1'b0;
                lhs_value    = kce_pkg::OPERAND_W'(lhs_value * 10 + (key - kce_pkg::KEY_ZERO));
                digits_taken = digits_taken + 1'b1;
                if (digits_taken >= N_DIGITS) begin
                    digits_taken = '0;
                    entry_phase  = kce_pkg::PH_OPER;
                end else begin
                    entry_phase = kce_pkg::PH_FIRST;
                end
            end
        endcase
        return 1'b1;
    endfunction

    // Offer one key after a random gap; hold it until accepted, then record
    // what it should yield. Returns at the falling edge after the accept.
    task automatic send_key(input logic [kce_pkg::KEY_W-1:0] key);
        int          gap;
        key_result_t r;
        gap = src_idle_on ? $urandom_range(0, 11) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= key;
        do @(posedge aclk); while (!s_tready);
        if (calc_key_result(key, r)) begin
            pending_results.push_back(r);
            keys_taken++;
        end
        @(negedge aclk);
    endtask

    task automatic send_text(input string keys);
        for (int i = 0; i < keys.len(); i++) send_key(keys[i]);
    endtask

    // Favor the extreme digits so that operands 000 and 999 come up often.
    function automatic logic [kce_pkg::KEY_W-1:0] rand_digit_key();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 2) return kce_pkg::KEY_ZERO;
        if (pick < 4) return kce_pkg::KEY_NINE;
        return kce_pkg::KEY_ZERO + kce_pkg::KEY_W'($urandom_range(0, 9));
    endfunction

    task automatic maybe_noise();
        if ($urandom_range(0, 19) == 0) send_key(kce_pkg::KEY_W'($urandom_range(0, 255)));
    endtask

    // One full entry with random operands and operator, sprinkled with stray keys.
    task automatic send_entry();
        logic [kce_pkg::KEY_W-1:0] op_key;
        bit                        zero_divisor;
        for (int i = 0; i < N_DIGITS; i++) begin
            maybe_noise();
            send_key(rand_digit_key());
        end
        op_key       = op_keys[$urandom_range(0, 3)];
        zero_divisor = (op_key == kce_pkg::KEY_SLASH) && ($urandom_range(0, 3) == 0);
        maybe_noise();
        send_key(op_key);
        for (int i = 0; i < N_DIGITS; i++) begin
            maybe_noise();
            send_key(zero_divisor ? kce_pkg::KEY_ZERO : rand_digit_key());
        end
    endtask

    task automatic test_directed_keys();
        send_key(8'hFF);               // drop: not a digit in first operand entry
        send_text("999");
        send_key(kce_pkg::KEY_NINE);   // drop: digit while an operator is due
        send_text("*999");             // largest product
        send_text("000-999");          // most negative difference
        send_text("123/000");          // division by zero
        send_text("999+999");
    endtask

    task automatic test_random_entries();
        int target;
        int entry_n;
        target  = keys_taken + RANDOM_KEYS;
        entry_n = 0;
        while (keys_taken < target) begin
            // Switch idling per block of entries so some stretches run flat out.
            if (entry_n % 16 == 0) begin
                src_idle_on  = ($urandom_range(0, 3) != 0);
                sink_idle_on = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 4) != 0) begin
                send_entry();
            end else begin
                // Broken entry: a burst of arbitrary keys.
                repeat ($urandom_range(1, 8)) send_key(kce_pkg::KEY_W'($urandom_range(0, 255)));
            end
            entry_n++;
        end
        src_idle_on  = 1'b1;
        sink_idle_on = 1'b1;
    endtask

    // Hold the output off for a long stretch while keys keep coming, so the
    // output register fills and the input stalls.
    task automatic test_output_stall();
        src_idle_on      = 1'b0;
        sink_hold_cycles = 300;
        repeat (3) send_entry();
        src_idle_on = 1'b1;
    endtask

    // Receiver: draw a stall before each result item, or take a requested hold.
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        @(negedge aclk);
        forever begin
            if (sink_hold_cycles != 0) begin
                stall            = sink_hold_cycles;
                sink_hold_cycles = 0;
            end else begin
                stall = sink_idle_on ? $urandom_range(0, 11) : 0;
            end
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
            @(negedge aclk);
        end
    end

    // Compare every accepted result item with the oldest expectation.
    always @(posedge aclk) begin
        key_result_t got;
        key_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser, m_tdata[28:8], m_tlast, m_tdata[7:0]};
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result item: echo=%h fin=%0b value=%0d err=%0b",
                             got.echo, got.fin, $signed(got.value), got.div_err);
            end else begin
                want = pending_results.pop_front();
                if (got.echo !== want.echo || got.fin !== want.fin ||
                    got.value !== want.value || got.div_err !== want.div_err) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch: expected echo=%h fin=%0b value=%0d err=%0b",
                                 want.echo, want.fin, $signed(want.value), want.div_err);
                        $display("          got      echo=%h fin=%0b value=%0d err=%0b",
                                 got.echo, got.fin, $signed(got.value), got.div_err);
                    end
                end
            end
        end
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #4000000;
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        aresetn          = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        m_tready         = 1'b0;
        keys_taken       = 0;
        fail_count       = 0;
        src_idle_on      = 1'b1;
        sink_idle_on     = 1'b1;
        sink_hold_cycles = 0;
        clear_entry();
        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_directed_keys();
        test_random_entries();
        test_output_stall();

        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        // Let any late stray result item show up.
        repeat (30) @(posedge aclk);
        if (fail_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule

`default_nettype wire

### filelist.f
design/kce_pkg.sv
design/kce_alu.sv
design/keypad_calculator_entry_core.sv
tb/tb.sv
